/* src/gds_pkg.sv */
// gds_pkg: shared types, action codes and calendar helpers for gregorian_date_step
// no dependencies
package gds_pkg;

  localparam int DAY_W = 6;
  localparam int MON_W = 4;
  localparam int YEAR_W = 16;
  localparam int YEAR_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ACT_CHECK = 2'd0,
    ACT_NEXT  = 2'd1,
    ACT_PREV  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;
  localparam logic [DAY_W-1:0] DAY_FIRST = 6'd1;
  localparam logic [DAY_W-1:0] DAY_LAST_DEC = 6'd31;

  typedef struct packed {
    logic [1:0]        action;
    logic [DAY_W-1:0]  day_in;
    logic [MON_W-1:0]  month_in;
    logic [YEAR_W-1:0] year_in;
  } item_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day_out;
    logic [MON_W-1:0]  month_out;
    logic [YEAR_W-1:0] year_out;
    logic              date_valid;
    logic              year_saturated;
  } result_t;

  // date with its leap flag, handed to the stepping logic
  typedef struct packed {
    logic [1:0]        action;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic              leap;
  } date_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 6'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 6'd30;
      MON_FEB:                                    len = leap ? 6'd29 : 6'd28;
      default:                                    len = 6'd0;
    endcase
    return len;
  endfunction

endpackage

/* src/gds_step.sv */
// gds_step: validity check and next/previous day selection for one date
// depends on gds_pkg (date_t, result_t, month_len, action codes)
module gds_step #(
  parameter int YEAR_BITS = gds_pkg::YEAR_BITS_DEF
) (
  input  gds_pkg::date_t   date,
  output gds_pkg::result_t result
);

  localparam logic [32:0] YEAR_MAX = (33'd1 << YEAR_BITS) - 33'd1;

  logic [gds_pkg::DAY_W-1:0] len_cur;
  logic [gds_pkg::DAY_W-1:0] len_prev;
  logic [gds_pkg::MON_W-1:0] month_dec;
  logic                      ok;
  logic                      at_max;

  assign month_dec = date.month - 4'd1;
  assign len_cur   = gds_pkg::month_len(date.month, date.leap);
  assign len_prev  = gds_pkg::month_len(month_dec, date.leap);
  assign at_max    = ({17'd0, date.year} == YEAR_MAX);
  // len_cur is zero for a bad month, so that case fails the day check too
  assign ok = (date.year != '0) && (date.day != '0) && (date.day <= len_cur);

  always_comb begin
    result.day_out        = date.day;
    result.month_out      = date.month;
    result.year_out       = date.year;
    result.date_valid     = ok;
    result.year_saturated = 1'b0;
    if (ok && date.action == gds_pkg::ACT_NEXT) begin
      if (date.day == len_cur) begin
        if (date.month == gds_pkg::MON_DEC) begin
          if (at_max) begin
            result.year_saturated = 1'b1;
          end else begin
            result.day_out   = gds_pkg::DAY_FIRST;
            result.month_out = gds_pkg::MON_JAN;
            result.year_out  = date.year + 16'd1;
          end
        end else begin
          result.day_out   = gds_pkg::DAY_FIRST;
          result.month_out = date.month + 4'd1;
        end
      end else begin
        result.day_out = date.day + 6'd1;
      end
    end else if (ok && date.action == gds_pkg::ACT_PREV) begin
      if (date.day == gds_pkg::DAY_FIRST) begin
        if (date.month == gds_pkg::MON_JAN) begin
          if (date.year > 16'd1) begin
            result.day_out   = gds_pkg::DAY_LAST_DEC;
            result.month_out = gds_pkg::MON_DEC;
            result.year_out  = date.year - 16'd1;
          end
        end else begin
          result.month_out = month_dec;
          result.day_out   = len_prev;
        end
      end else begin
        result.day_out = date.day - 6'd1;
      end
    end
  end

endmodule

/* src/gregorian_date_step.sv */
// gregorian_date_step: top level, four-stage pipeline around the leap test and gds_step
// depends on gds_pkg and gds_step
//
// Checks a Gregorian date and optionally steps it one day forward or back. A new
// transaction can be accepted every cycle while the output is not stalled. Each one
// passes four register stages (nibble residue sum, residue fold, leap decision,
// validity and stepping), the first of them loaded at the accepting edge.
// The stages stall together from the output backward, and a stage that holds no
// transaction is refilled even while later stages are stalled. Years are taken modulo
// 2^YEAR_BITS; stepping past 31 December of the largest year holds the date and sets
// year_saturated.
module gregorian_date_step #(
  parameter int YEAR_BITS = gds_pkg::YEAR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  gds_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output gds_pkg::result_t result
);

  localparam logic [32:0] YEAR_FULL = (33'd1 << YEAR_BITS) - 33'd1;
  localparam logic [gds_pkg::YEAR_W-1:0] YEAR_MASK = YEAR_FULL[gds_pkg::YEAR_W-1:0];

  // stage control
  logic v1, v2, v3;
  logic en1, en2, en3, en4;

  // stage payloads
  gds_pkg::date_t s1_date, s2_date, s3_date;
  logic [9:0] s1_res;
  logic [7:0] s2_res;
  logic       s2_div4, s2_div16;

  logic [gds_pkg::YEAR_W-1:0] y_in;
  logic [9:0] res1_next;
  logic [7:0] res2_next;
  logic [6:0] res3;
  logic       div25;
  gds_pkg::result_t step_res;

  assign en4 = !result_valid || result_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign item_ready = en1;

  // residue mod 25 from nibbles: 16^1, 16^2, 16^3 are 16, 6, 21 mod 25
  assign y_in = item.year_in & YEAR_MASK;
  assign res1_next = 10'(y_in[3:0]) + {2'b0, y_in[7:4], 4'b0}
                   + 10'(y_in[11:8]) * 10'd6 + 10'(y_in[15:12]) * 10'd21;
  // 32 is 7 mod 25
  assign res2_next = 8'(s1_res[4:0]) + 8'(s1_res[9:5]) * 8'd7;
  assign res3      = 7'(s2_res[4:0]) + 7'(s2_res[7:5]) * 7'd7;
  assign div25     = (res3 == 7'd0) || (res3 == 7'd25) || (res3 == 7'd50)
                  || (res3 == 7'd75);

  gds_step #(
    .YEAR_BITS(YEAR_BITS)
  ) u_step (
    .date  (s3_date),
    .result(step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) v1 <= item_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) result_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_date.action <= item.action;
      s1_date.day    <= item.day_in;
      s1_date.month  <= item.month_in;
      s1_date.year   <= y_in;
      s1_date.leap   <= 1'b0;
      s1_res         <= res1_next;
    end
    if (en2) begin
      s2_date  <= s1_date;
      s2_res   <= res2_next;
      s2_div4  <= (s1_date.year[1:0] == 2'd0);
      s2_div16 <= (s1_date.year[3:0] == 4'd0);
    end
    if (en3) begin
      s3_date.action <= s2_date.action;
      s3_date.day    <= s2_date.day;
      s3_date.month  <= s2_date.month;
      s3_date.year   <= s2_date.year;
      // div by 100 is div by 4 and 25; div by 400 is div by 16 and 25
      s3_date.leap   <= (s2_div4 && !div25) || (s2_div16 && div25);
    end
    if (en4) begin
      result <= step_res;
    end
  end

`ifndef SYNTHESIS
  a_sat_only_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.year_saturated |-> result.date_valid)
    else $error("year_saturated on an invalid date");

  a_sat_year_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.year_saturated |->
      result.day_out == gds_pkg::DAY_LAST_DEC && result.month_out == gds_pkg::MON_DEC)
    else $error("year_saturated away from the last day of the year");

  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> item_ready)
    else $error("empty first stage but input not ready");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking testbench for gregorian_date_step, with its own date predictor
// depends on gds_pkg and the gregorian_date_step rtl
module tb_top;
  import gds_pkg::*;

  localparam int YEAR_BITS = 16;
  localparam int unsigned YEAR_LIMIT = (32'h1 << YEAR_BITS) - 1;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTS = 50;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  result_t expected_dates[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      source_gaps = 1'b1;
  bit      sink_stalls = 1'b1;
  int      hold_requests = 0;
  int      hold_served = 0;
  int      hold_left = 0;
  int      sink_gap_left = 0;

  gregorian_date_step #(.YEAR_BITS(YEAR_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] m,
                                                     input int unsigned y);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 6'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 6'd30;
      MON_FEB:                                    return is_leap(y) ? 6'd29 : 6'd28;
      default:                                    return 6'd0;
    endcase
  endfunction

  // expected result of one transaction
  function automatic result_t step_date(input item_t it);
    result_t          r;
    int unsigned      y;
    logic [DAY_W-1:0] d;
    logic [MON_W-1:0] m;
    logic             ok;
    logic             sat;
    y = it.year_in & YEAR_LIMIT;
    d = it.day_in;
    m = it.month_in;
    sat = 1'b0;
    ok = (y >= 1) && (m >= MON_JAN) && (m <= MON_DEC) && (d >= DAY_FIRST) &&
         (d <= days_in_month(m, y));
    if (ok && it.action == ACT_NEXT) begin
      if (d == days_in_month(m, y)) begin
        if (m == MON_DEC) begin
          if (y == YEAR_LIMIT) begin
            sat = 1'b1;
          end else begin
            d = DAY_FIRST;
            m = MON_JAN;
            y = y + 1;
          end
        end else begin
          d = DAY_FIRST;
          m = m + 1'b1;
        end
      end else begin
        d = d + 1'b1;
      end
    end else if (ok && it.action == ACT_PREV) begin
      if (d == DAY_FIRST) begin
        if (m == MON_JAN) begin
          // 1 january of year one stays put
          if (y > 1) begin
            d = DAY_LAST_DEC;
            m = MON_DEC;
            y = y - 1;
          end
        end else begin
          m = m - 1'b1;
          d = days_in_month(m, y);
        end
      end else begin
        d = d - 1'b1;
      end
    end
    r.day_out = d;
    r.month_out = m;
    r.year_out = YEAR_W'(y);
    r.date_valid = ok;
    r.year_saturated = sat;
    return r;
  endfunction

  function automatic item_t make_date(input action_t a, input int unsigned d,
                                      input int unsigned m, input int unsigned y);
    item_t it;
    it.action = a;
    it.day_in = DAY_W'(d);
    it.month_in = MON_W'(m);
    it.year_in = YEAR_W'(y);
    return it;
  endfunction

  // mostly well-formed dates near month, year and leap boundaries, some raw noise
  function automatic item_t random_date();
    logic [31:0]      raw;
    int unsigned      y;
    int unsigned      m;
    int unsigned      d;
    int unsigned      len;
    int unsigned      pick;
    action_t          a;
    raw = $urandom;
    if ($urandom_range(0, 99) < 15) return raw[$bits(item_t)-1:0];
    case ($urandom_range(0, 9))
      0:       y = $urandom_range(1, 2);
      1:       y = YEAR_LIMIT - $urandom_range(0, 1);
      2:       y = 400 * $urandom_range(1, 163);
      3:       y = 100 * $urandom_range(1, 655);
      4:       y = 4 * $urandom_range(1, 16383);
      default: y = $urandom_range(1, YEAR_LIMIT);
    endcase
    case ($urandom_range(0, 4))
      0:       m = MON_DEC;
      1:       m = MON_JAN;
      2:       m = MON_FEB;
      default: m = $urandom_range(1, 12);
    endcase
    len = days_in_month(MON_W'(m), y);
    case ($urandom_range(0, 4))
      0:       d = DAY_FIRST;
      1:       d = len;
      2:       d = len + $urandom_range(0, 2) - 1;
      default: d = $urandom_range(1, len);
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0) a = ACT_CHECK;
    else if (pick == 1) a = ACT_NONE;
    else if (pick < 6) a = ACT_NEXT;
    else a = ACT_PREV;
    return make_date(a, d, m, y);
  endfunction

  function automatic int idle_gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTS)
      $display("tb_top: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_date(input item_t it);
    int gap;
    gap = source_gaps ? idle_gap_length() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected_dates.push_back(step_date(it));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (expected_dates.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed_dates();
    send_date(make_date(ACT_CHECK, 15, 6, 2024));
    send_date(make_date(ACT_NONE, 63, 15, 65535));
    send_date(make_date(ACT_NEXT, 0, 0, 0));
    send_date(make_date(ACT_PREV, 1, 13, 2000));
    send_date(make_date(ACT_NEXT, 32, 1, 2000));
    send_date(make_date(ACT_NEXT, 29, 2, 1900));
    send_date(make_date(ACT_NEXT, 29, 2, 2000));
    send_date(make_date(ACT_NEXT, 28, 2, 2023));
    send_date(make_date(ACT_NEXT, 28, 2, 2024));
    send_date(make_date(ACT_PREV, 1, 3, 2024));
    send_date(make_date(ACT_PREV, 1, 3, 2100));
    send_date(make_date(ACT_NEXT, 31, 12, YEAR_LIMIT));
    send_date(make_date(ACT_CHECK, 31, 12, YEAR_LIMIT));
    send_date(make_date(ACT_PREV, 31, 12, YEAR_LIMIT));
    send_date(make_date(ACT_NEXT, 31, 12, 2023));
    send_date(make_date(ACT_PREV, 1, 1, 1));
    send_date(make_date(ACT_NEXT, 1, 1, 1));
    send_date(make_date(ACT_PREV, 1, 1, 2024));
    send_date(make_date(ACT_NEXT, 30, 4, 2024));
    send_date(make_date(ACT_PREV, 1, 5, 2024));
    send_date(make_date(ACT_NONE, 10, 7, 1999));
    send_date(make_date(ACT_NEXT, 31, 4, 2024));
    send_date(make_date(ACT_PREV, 0, 1, 100));
    send_date(make_date(ACT_NEXT, 29, 2, 65532));
    wait_for_results();
  endtask

  task automatic test_random_dates(input int count);
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (count) send_date(random_date());
  endtask

  // sink holds off for a long stretch while the source keeps offering
  task automatic test_output_hold();
    source_gaps = 1'b0;
    hold_requests++;
    repeat (60) send_date(random_date());
    wait_for_results();
    source_gaps = 1'b1;
  endtask

  task automatic test_back_to_back();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (200) send_date(random_date());
    wait_for_results();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // sink side: random stalls, plus a long hold when one is requested
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES - 1;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (!sink_stalls) begin
      result_ready <= 1'b1;
    end else if (sink_gap_left > 0) begin
      sink_gap_left <= sink_gap_left - 1;
      result_ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: result_ready <= 1'b1;
        [70:93]: begin
          result_ready <= 1'b0;
          sink_gap_left <= $urandom_range(0, 2);
        end
        default: begin
          result_ready <= 1'b0;
          sink_gap_left <= $urandom_range(10, 40);
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("result with no transaction pending", result.year_out, 0);
      end else begin
        want = expected_dates.pop_front();
        if (result.day_out !== want.day_out)
          report_mismatch("day_out", result.day_out, want.day_out);
        if (result.month_out !== want.month_out)
          report_mismatch("month_out", result.month_out, want.month_out);
        if (result.year_out !== want.year_out)
          report_mismatch("year_out", result.year_out, want.year_out);
        if (result.date_valid !== want.date_valid)
          report_mismatch("date_valid", result.date_valid, want.date_valid);
        if (result.year_saturated !== want.year_saturated)
          report_mismatch("year_saturated", result.year_saturated, want.year_saturated);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_dates();
    test_random_dates(1000);
    test_output_hold();
    test_back_to_back();
    test_random_dates(470);
    wait_for_results();
    repeat (12) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
